// ----- design/i2cme_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
package i2cme_pkg;

    // Operation codes carried by an input transaction
    typedef logic [2:0] t_op;
    localparam t_op OP_TICK  = 3'd0;
    localparam t_op OP_START = 3'd1;
    localparam t_op OP_STOP  = 3'd2;
    localparam t_op OP_WRITE = 3'd3;
    localparam t_op OP_READ  = 3'd4;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_SHORT = 2'd0;
    localparam t_cfg_index CFG_LONG  = 2'd1;
    localparam t_cfg_index CFG_WAIT  = 2'd2;

    localparam logic [15:0] SHORT_RESET = 16'd4;
    localparam logic [15:0] LONG_RESET  = 16'd8;
    localparam logic [15:0] WAIT_RESET  = 16'd2;

    // Bus phase indexes, numbered per command
    typedef logic [3:0] t_phase;
    localparam t_phase PH_FIRST = 4'd0;

    localparam t_phase START_SCL_HI = 4'd0;
    localparam t_phase START_SDA_LO = 4'd1;

    localparam t_phase STOP_SDA_LO = 4'd0;
    localparam t_phase STOP_SCL_HI = 4'd1;
    localparam t_phase STOP_SDA_HI = 4'd2;

    localparam t_phase WR_SCL_LO     = 4'd0;
    localparam t_phase WR_DATA       = 4'd1;
    localparam t_phase WR_SCL_HI     = 4'd2;
    localparam t_phase WR_SHIFT      = 4'd3;
    localparam t_phase WR_ACK_SCL_LO = 4'd4;
    localparam t_phase WR_ACK_REL    = 4'd5;
    localparam t_phase WR_ACK_SCL_HI = 4'd6;
    localparam t_phase WR_ACK_HOLD   = 4'd7;
    localparam t_phase WR_ACK_SAMPLE = 4'd8;
    localparam t_phase WR_END        = 4'd9;

    localparam t_phase RD_SETUP      = 4'd0;
    localparam t_phase RD_SCL_HI     = 4'd1;
    localparam t_phase RD_WAIT       = 4'd2;
    localparam t_phase RD_SAMPLE     = 4'd3;
    localparam t_phase RD_ACK_DRIVE  = 4'd4;
    localparam t_phase RD_ACK_SCL_HI = 4'd5;
    localparam t_phase RD_ACK_SCL_LO = 4'd6;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [7:0] MSB_MASK      = 8'h80;

    // Phase hold times
    typedef struct packed {
        logic [15:0] short_ticks;
        logic [15:0] long_ticks;
        logic [15:0] wait_ticks;
    } t_cfg;

    // Engine state
    typedef struct packed {
        t_op         cmd;
        t_phase      phase;
        logic [15:0] delay;
        logic [3:0]  bit_cnt;
        logic [7:0]  shift;
        logic        scl;
        logic        sda;
        logic        ack_flag;
        logic        ack_req;
        logic [7:0]  rx_latch;
    } t_eng_state;

    localparam t_eng_state ENG_RESET = '{
        cmd:      OP_TICK,
        phase:    PH_FIRST,
        delay:    16'd0,
        bit_cnt:  4'd0,
        shift:    8'd0,
        scl:      1'b1,
        sda:      1'b1,
        ack_flag: 1'b0,
        ack_req:  1'b0,
        rx_latch: 8'd0
    };

    // Result fields produced for one transaction
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack;
    } t_result;

endpackage

// ----- design/i2cme_phase_step.sv -----
// One bus phase step: applies the next phase of the active command when its hold has run out.
module i2cme_phase_step (
    input  i2cme_pkg::t_eng_state i_state,
    input  i2cme_pkg::t_cfg       i_cfg,
    input  logic                  i_sda_in,
    output i2cme_pkg::t_eng_state o_state,
    output logic                  o_done
);
    import i2cme_pkg::*;

    logic [3:0] w_bit_next;
    logic [7:0] w_shift_out;
    logic [7:0] w_shift_in;

    assign w_bit_next  = i_state.bit_cnt + 4'd1;
    assign w_shift_out = {i_state.shift[6:0], 1'b0};
    assign w_shift_in  = {i_state.shift[6:0], i_sda_in};

    // Apply one phase of the active command
    always_comb begin
        o_state = i_state;
        o_done  = 1'b0;
        if (i_state.cmd != OP_TICK && i_state.delay == 16'd0) begin
            unique case (i_state.cmd)
                OP_START: begin
                    unique case (i_state.phase)
                        START_SCL_HI: begin
                            o_state.scl   = 1'b1;
                            o_state.delay = i_cfg.long_ticks;
                            o_state.phase = START_SDA_LO;
                        end
                        START_SDA_LO: begin
                            o_state.sda   = 1'b0;
                            o_state.delay = i_cfg.long_ticks;
                            o_state.phase = START_SDA_LO + 4'd1;
                        end
                        default: o_done = 1'b1;
                    endcase
                end
                OP_STOP: begin
                    unique case (i_state.phase)
                        STOP_SDA_LO: begin
                            o_state.sda   = 1'b0;
                            o_state.delay = i_cfg.long_ticks;
                            o_state.phase = STOP_SCL_HI;
                        end
                        STOP_SCL_HI: begin
                            o_state.scl   = 1'b1;
                            o_state.delay = i_cfg.short_ticks;
                            o_state.phase = STOP_SDA_HI;
                        end
                        STOP_SDA_HI: begin
                            o_state.sda   = 1'b1;
                            o_state.delay = i_cfg.long_ticks;
                            o_state.phase = STOP_SDA_HI + 4'd1;
                        end
                        default: o_done = 1'b1;
                    endcase
                end
                OP_WRITE: begin
                    unique case (i_state.phase)
                        WR_SCL_LO: begin
                            o_state.scl   = 1'b0;
                            o_state.delay = i_cfg.short_ticks;
                            o_state.phase = WR_DATA;
                        end
                        WR_DATA: begin
                            o_state.sda   = |(i_state.shift & MSB_MASK);
                            o_state.delay = i_cfg.short_ticks;
                            o_state.phase = WR_SCL_HI;
                        end
                        WR_SCL_HI: begin
                            o_state.scl   = 1'b1;
                            o_state.delay = i_cfg.short_ticks;
                            o_state.phase = WR_SHIFT;
                        end
                        WR_SHIFT: begin
                            o_state.shift   = w_shift_out;
                            o_state.bit_cnt = w_bit_next;
                            o_state.delay   = i_cfg.wait_ticks;
                            o_state.phase   = (w_bit_next < BITS_PER_BYTE) ? WR_SCL_LO
                                                                           : WR_ACK_SCL_LO;
                        end
                        WR_ACK_SCL_LO: begin
                            o_state.scl   = 1'b0;
                            o_state.delay = i_cfg.short_ticks;
                            o_state.phase = WR_ACK_REL;
                        end
                        WR_ACK_REL: begin
                            o_state.sda   = 1'b1;
                            o_state.delay = i_cfg.long_ticks;
                            o_state.phase = WR_ACK_SCL_HI;
                        end
                        WR_ACK_SCL_HI: begin
                            o_state.scl   = 1'b1;
                            o_state.delay = i_cfg.long_ticks;
                            o_state.phase = WR_ACK_HOLD;
                        end
                        WR_ACK_HOLD: begin
                            o_state.sda   = 1'b1;
                            o_state.delay = i_cfg.long_ticks;
                            o_state.phase = WR_ACK_SAMPLE;
                        end
                        WR_ACK_SAMPLE: begin
                            o_state.ack_flag = ~i_sda_in;
                            o_state.scl      = 1'b0;
                            o_state.delay    = i_cfg.long_ticks;
                            o_state.phase    = WR_END;
                        end
                        default: o_done = 1'b1;
                    endcase
                end
                OP_READ: begin
                    unique case (i_state.phase)
                        RD_SETUP: begin
                            o_state.sda   = 1'b1;
                            o_state.scl   = 1'b0;
                            o_state.delay = i_cfg.short_ticks;
                            o_state.phase = RD_SCL_HI;
                        end
                        RD_SCL_HI: begin
                            o_state.scl   = 1'b1;
                            o_state.delay = i_cfg.short_ticks;
                            o_state.phase = RD_WAIT;
                        end
                        RD_WAIT: begin
                            o_state.delay = i_cfg.wait_ticks;
                            o_state.phase = RD_SAMPLE;
                        end
                        RD_SAMPLE: begin
                            o_state.shift   = w_shift_in;
                            o_state.bit_cnt = w_bit_next;
                            o_state.scl     = 1'b0;
                            if (w_bit_next < BITS_PER_BYTE) begin
                                o_state.delay = i_cfg.short_ticks;
                                o_state.phase = RD_SCL_HI;
                            end else begin
                                o_state.sda   = 1'b1;
                                o_state.delay = i_cfg.long_ticks;
                                o_state.phase = RD_ACK_DRIVE;
                            end
                        end
                        RD_ACK_DRIVE: begin
                            if (i_state.ack_req) begin
                                o_state.sda   = 1'b0;
                                o_state.delay = i_cfg.long_ticks;
                            end else begin
                                o_state.delay = 16'd0;
                            end
                            o_state.phase = RD_ACK_SCL_HI;
                        end
                        RD_ACK_SCL_HI: begin
                            o_state.scl   = 1'b1;
                            o_state.delay = i_cfg.long_ticks;
                            o_state.phase = RD_ACK_SCL_LO;
                        end
                        RD_ACK_SCL_LO: begin
                            o_state.scl   = 1'b0;
                            o_state.delay = i_cfg.long_ticks;
                            o_state.phase = RD_ACK_SCL_LO + 4'd1;
                        end
                        default: begin
                            o_state.sda      = 1'b1;
                            o_state.rx_latch = i_state.shift;
                            o_done           = 1'b1;
                        end
                    endcase
                end
                default: o_done = 1'b1;
            endcase
            // Drop back to idle once the command has finished
            if (o_done) begin
                o_state.cmd   = OP_TICK;
                o_state.phase = PH_FIRST;
                o_state.delay = 16'd0;
            end
        end
    end

endmodule

// ----- design/i2cme_engine.sv -----
// Command engine: takes a command or tick, counts the hold down and chains two phase steps.
module i2cme_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step_en,
    input  logic                 i_cont,
    input  i2cme_pkg::t_op       i_operation,
    input  logic [7:0]           i_tx_byte,
    input  logic                 i_send_ack,
    input  logic                 i_sda_in,
    input  i2cme_pkg::t_cfg      i_cfg,
    output i2cme_pkg::t_result   o_result,
    output logic                 o_chain_more,
    output logic                 o_rejected
);
    import i2cme_pkg::*;

    t_eng_state r_state;
    t_eng_state n_state;
    t_eng_state w_entry;
    t_eng_state w_mid;
    logic       w_is_cmd;
    logic       w_busy;
    logic       w_done_a;
    logic       w_done_b;

    assign w_is_cmd = (i_operation >= OP_START) && (i_operation <= OP_READ);
    assign w_busy   = (r_state.cmd != OP_TICK);

    // Unless chaining, take a new command, or count the current hold down by one tick
    always_comb begin
        w_entry    = r_state;
        o_rejected = 1'b0;
        if (!i_cont) begin
            if (w_is_cmd && !w_busy) begin
                w_entry.cmd     = i_operation;
                w_entry.phase   = PH_FIRST;
                w_entry.delay   = 16'd0;
                w_entry.bit_cnt = 4'd0;
                if (i_operation == OP_WRITE) begin
                    w_entry.shift = i_tx_byte;
                end
                if (i_operation == OP_READ) begin
                    w_entry.shift   = 8'd0;
                    w_entry.ack_req = i_send_ack;
                end
            end else begin
                o_rejected = w_is_cmd;
                if (w_busy && r_state.delay != 16'd0) begin
                    w_entry.delay = r_state.delay - 16'd1;
                end
            end
        end
    end

    // Two phase steps per cycle while stepping is enabled
    i2cme_phase_step u_step_a (
        .i_state  (w_entry),
        .i_cfg    (i_cfg),
        .i_sda_in (i_sda_in),
        .o_state  (w_mid),
        .o_done   (w_done_a)
    );

    i2cme_phase_step u_step_b (
        .i_state  (w_mid),
        .i_cfg    (i_cfg),
        .i_sda_in (i_sda_in),
        .o_state  (n_state),
        .o_done   (w_done_b)
    );

    assign o_chain_more = (n_state.cmd != OP_TICK) && (n_state.delay == 16'd0);

    assign o_result.scl     = n_state.scl;
    assign o_result.sda     = n_state.sda;
    assign o_result.busy    = (n_state.cmd != OP_TICK);
    assign o_result.done    = w_done_a | w_done_b;
    assign o_result.rx_byte = n_state.rx_latch;
    assign o_result.ack     = n_state.ack_flag;

    // Hold engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ENG_RESET;
        end else if (i_step_en) begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/i2c_master_byte_engine.sv -----
// Top level of the I2C master byte engine: channels, configuration registers and result register.
//
// Each transaction is a tick or a command (start, stop, write byte, read byte) and yields one
// result with the SCL and SDA drive levels after it. Throughput is one transaction per clock
// while the result register is not stalled and the short and long hold registers are nonzero;
// each transaction passes from the input register through the engine into the result register.
// The engine applies at most two bus phases per clock; when holds of zero let more phases pass
// on one transaction, that transaction stays in the input register until the engine has applied
// them all, and only then does its result appear. A full result register that is stalled holds
// the engine, while one more transaction can still wait in the input register.
module i2c_master_byte_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  i2cme_pkg::t_cfg_index i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_operation,
    input  logic [7:0]            i_tx_byte,
    input  logic                  i_send_ack,
    input  logic                  i_sda_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_scl_level,
    output logic                  o_sda_level,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [7:0]            o_rx_byte,
    output logic                  o_ack_received,
    output logic                  o_command_rejected
);
    import i2cme_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    r_cont;
    logic    r_rej;
    t_op     r_op;
    logic [7:0] r_tx;
    logic    r_sack;
    logic    r_sda;
    logic    r_out_valid;
    t_result r_out;
    logic    r_out_rej;

    t_result w_result;
    logic    w_chain_more;
    logic    w_rej_first;
    logic    w_out_free;
    logic    w_step_en;
    logic    w_item_done;
    logic    w_in_accept;
    logic    w_rejected;

    // Configuration writes; an unused index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_ticks <= SHORT_RESET;
            r_cfg.long_ticks  <= LONG_RESET;
            r_cfg.wait_ticks  <= WAIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SHORT: r_cfg.short_ticks <= i_cfg_data;
                CFG_LONG:  r_cfg.long_ticks  <= i_cfg_data;
                CFG_WAIT:  r_cfg.wait_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake control
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_step_en   = r_in_valid && w_out_free;
    assign w_item_done = w_step_en && !w_chain_more;
    assign o_in_stall  = r_in_valid && !w_item_done;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_rejected  = r_cont ? r_rej : w_rej_first;

    // Hold the accepted transaction until the engine has finished with it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cont     <= 1'b0;
            r_rej      <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_item_done) begin
                r_in_valid <= 1'b0;
            end
            if (w_in_accept || w_item_done) begin
                r_cont <= 1'b0;
            end else if (w_step_en) begin
                r_cont <= 1'b1;
            end
            if (w_step_en && !r_cont) begin
                r_rej <= w_rej_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op   <= i_operation;
            r_tx   <= i_tx_byte;
            r_sack <= i_send_ack;
            r_sda  <= i_sda_in;
        end
    end

    i2cme_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_en    (w_step_en),
        .i_cont       (r_cont),
        .i_operation  (r_op),
        .i_tx_byte    (r_tx),
        .i_send_ack   (r_sack),
        .i_sda_in     (r_sda),
        .i_cfg        (r_cfg),
        .o_result     (w_result),
        .o_chain_more (w_chain_more),
        .o_rejected   (w_rej_first)
    );

    // Load the result register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_out.scl       <= 1'b1;
            r_out.sda       <= 1'b1;
            r_out.busy      <= 1'b0;
            r_out.done      <= 1'b0;
            r_out.rx_byte   <= 8'd0;
            r_out.ack       <= 1'b0;
            r_out_rej       <= 1'b0;
        end else if (w_item_done) begin
            r_out_valid <= 1'b1;
            r_out       <= w_result;
            r_out_rej   <= w_rejected;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_scl_level        = r_out.scl;
    assign o_sda_level        = r_out.sda;
    assign o_busy_res         = r_out.busy;
    assign o_done_res         = r_out.done;
    assign o_rx_byte          = r_out.rx_byte;
    assign o_ack_received     = r_out.ack;
    assign o_command_rejected = r_out_rej;

    // A finishing transaction leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done result reports busy");

    // The read byte only changes with a finishing command
    a_rx_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_rx_byte != $past(o_rx_byte)) |-> o_done_res)
        else $error("read byte changed without a finished command");

    // Phase chaining only continues on a held transaction
    a_cont_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cont |-> r_in_valid && o_in_stall == !w_item_done)
        else $error("phase chaining without a held transaction");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the I2C master byte engine: directed table, then random traffic.
module tb_top;
    import i2cme_pkg::*;

    // Codes outside the command set, and a register index the block does not decode
    localparam t_op        OP_SPARE_LO  = 3'd5;
    localparam t_op        OP_SPARE_MID = 3'd6;
    localparam t_op        OP_SPARE_HI  = 3'd7;
    localparam t_cfg_index CFG_UNUSED   = 2'd3;

    // Phase index reached once the last bus phase of a command has been applied
    localparam t_phase PH_START_END = 4'd2;
    localparam t_phase PH_STOP_END  = 4'd3;
    localparam t_phase PH_RD_END    = 4'd7;

    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
        logic       rej;
    } t_bus_res;

    // One stimulus row; typed rows carry their result written out by hand
    typedef struct packed {
        t_op        op;
        logic [7:0] txb;
        logic       sack;
        logic       sda;
        logic [7:0] reps;
        logic       zero_holds;
        logic       typed;
        t_bus_res   res;
    } t_stim_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    t_cfg_index  i_cfg_index    = CFG_SHORT;
    logic [15:0] i_cfg_data     = 16'd0;
    logic        i_in_valid     = 1'b0;
    logic [2:0]  i_operation    = OP_TICK;
    logic [7:0]  i_tx_byte      = 8'd0;
    logic        i_send_ack     = 1'b0;
    logic        i_sda_in       = 1'b1;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_scl_level;
    logic        o_sda_level;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_rx_byte;
    logic        o_ack_received;
    logic        o_command_rejected;

    i2c_master_byte_engine dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_tx_byte          (i_tx_byte),
        .i_send_ack         (i_send_ack),
        .i_sda_in           (i_sda_in),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_scl_level        (o_scl_level),
        .o_sda_level        (o_sda_level),
        .o_busy_res         (o_busy_res),
        .o_done_res         (o_done_res),
        .o_rx_byte          (o_rx_byte),
        .o_ack_received     (o_ack_received),
        .o_command_rejected (o_command_rejected)
    );

    always #5 i_clk = ~i_clk;

    // Shadow hold registers
    logic [15:0] hold_short = SHORT_RESET;
    logic [15:0] hold_long  = LONG_RESET;
    logic [15:0] hold_wait  = WAIT_RESET;

    // Shadow bus engine state
    t_op         bus_cmd    = OP_TICK;
    t_phase      bus_phase  = PH_FIRST;
    logic [15:0] hold_cnt   = 16'd0;
    logic [3:0]  bit_cnt    = 4'd0;
    logic [7:0]  shreg      = 8'd0;
    logic        scl_q      = 1'b1;
    logic        sda_q      = 1'b1;
    logic        ack_seen   = 1'b0;
    logic        ack_wanted = 1'b0;
    logic [7:0]  rx_last    = 8'd0;
    logic        cmd_closed;

    t_stim_row   dir_rows[$];
    t_stim_row   item_q[$];
    t_bus_res    bus_results_q[$];
    t_stim_row   offer;
    int          random_left  = 0;
    bit          item_live    = 1'b0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    int          n_taken      = 0;
    int          n_results    = 0;
    int          n_cmds_done  = 0;
    int          n_refused    = 0;
    int          n_errs       = 0;
    int          quiet_cycles = 0;

    function automatic void close_command();
        bus_cmd    = OP_TICK;
        bus_phase  = PH_FIRST;
        hold_cnt   = 16'd0;
        cmd_closed = 1'b1;
    endfunction

    // Advance the shadow engine by one transaction and return its result
    function automatic t_bus_res step_bus(t_stim_row it);
        t_bus_res r;
        logic     is_cmd;
        r          = '0;
        cmd_closed = 1'b0;
        is_cmd     = (it.op >= OP_START) && (it.op <= OP_READ);
        if (is_cmd && bus_cmd == OP_TICK) begin
            bus_cmd   = it.op;
            bus_phase = PH_FIRST;
            hold_cnt  = 16'd0;
            bit_cnt   = 4'd0;
            if (it.op == OP_WRITE)
                shreg = it.txb;
            if (it.op == OP_READ) begin
                shreg      = 8'd0;
                ack_wanted = it.sack;
            end
        end else begin
            r.rej = is_cmd;
            if (bus_cmd != OP_TICK && hold_cnt != 16'd0)
                hold_cnt = hold_cnt - 16'd1;
        end
        // Apply every phase whose hold has run out
        while (bus_cmd != OP_TICK && hold_cnt == 16'd0) begin
            case (bus_cmd)
                OP_START: begin
                    case (bus_phase)
                        START_SCL_HI: begin
                            scl_q = 1'b1; hold_cnt = hold_long; bus_phase = START_SDA_LO;
                        end
                        START_SDA_LO: begin
                            sda_q = 1'b0; hold_cnt = hold_long; bus_phase = PH_START_END;
                        end
                        default: close_command();
                    endcase
                end
                OP_STOP: begin
                    case (bus_phase)
                        STOP_SDA_LO: begin
                            sda_q = 1'b0; hold_cnt = hold_long; bus_phase = STOP_SCL_HI;
                        end
                        STOP_SCL_HI: begin
                            scl_q = 1'b1; hold_cnt = hold_short; bus_phase = STOP_SDA_HI;
                        end
                        STOP_SDA_HI: begin
                            sda_q = 1'b1; hold_cnt = hold_long; bus_phase = PH_STOP_END;
                        end
                        default: close_command();
                    endcase
                end
                OP_WRITE: begin
                    case (bus_phase)
                        WR_SCL_LO: begin
                            scl_q = 1'b0; hold_cnt = hold_short; bus_phase = WR_DATA;
                        end
                        WR_DATA: begin
                            sda_q     = (shreg & MSB_MASK) != 8'd0;
                            hold_cnt  = hold_short;
                            bus_phase = WR_SCL_HI;
                        end
                        WR_SCL_HI: begin
                            scl_q = 1'b1; hold_cnt = hold_short; bus_phase = WR_SHIFT;
                        end
                        WR_SHIFT: begin
                            shreg     = shreg << 1;
                            bit_cnt   = bit_cnt + 4'd1;
                            hold_cnt  = hold_wait;
                            bus_phase = (bit_cnt < BITS_PER_BYTE) ? WR_SCL_LO : WR_ACK_SCL_LO;
                        end
                        WR_ACK_SCL_LO: begin
                            scl_q = 1'b0; hold_cnt = hold_short; bus_phase = WR_ACK_REL;
                        end
                        WR_ACK_REL: begin
                            sda_q = 1'b1; hold_cnt = hold_long; bus_phase = WR_ACK_SCL_HI;
                        end
                        WR_ACK_SCL_HI: begin
                            scl_q = 1'b1; hold_cnt = hold_long; bus_phase = WR_ACK_HOLD;
                        end
                        WR_ACK_HOLD: begin
                            sda_q = 1'b1; hold_cnt = hold_long; bus_phase = WR_ACK_SAMPLE;
                        end
                        WR_ACK_SAMPLE: begin
                            ack_seen  = ~it.sda;
                            scl_q     = 1'b0;
                            hold_cnt  = hold_long;
                            bus_phase = WR_END;
                        end
                        default: close_command();
                    endcase
                end
                OP_READ: begin
                    case (bus_phase)
                        RD_SETUP: begin
                            sda_q = 1'b1; scl_q = 1'b0;
                            hold_cnt = hold_short; bus_phase = RD_SCL_HI;
                        end
                        RD_SCL_HI: begin
                            scl_q = 1'b1; hold_cnt = hold_short; bus_phase = RD_WAIT;
                        end
                        RD_WAIT: begin
                            hold_cnt = hold_wait; bus_phase = RD_SAMPLE;
                        end
                        RD_SAMPLE: begin
                            shreg   = {shreg[6:0], it.sda};
                            bit_cnt = bit_cnt + 4'd1;
                            scl_q   = 1'b0;
                            if (bit_cnt < BITS_PER_BYTE) begin
                                hold_cnt = hold_short; bus_phase = RD_SCL_HI;
                            end else begin
                                sda_q = 1'b1; hold_cnt = hold_long; bus_phase = RD_ACK_DRIVE;
                            end
                        end
                        RD_ACK_DRIVE: begin
                            if (ack_wanted) begin
                                sda_q = 1'b0; hold_cnt = hold_long;
                            end else begin
                                hold_cnt = 16'd0;
                            end
                            bus_phase = RD_ACK_SCL_HI;
                        end
                        RD_ACK_SCL_HI: begin
                            scl_q = 1'b1; hold_cnt = hold_long; bus_phase = RD_ACK_SCL_LO;
                        end
                        RD_ACK_SCL_LO: begin
                            scl_q = 1'b0; hold_cnt = hold_long; bus_phase = PH_RD_END;
                        end
                        default: begin
                            sda_q   = 1'b1;
                            rx_last = shreg;
                            close_command();
                        end
                    endcase
                end
                default: close_command();
            endcase
        end
        r.scl  = scl_q;
        r.sda  = sda_q;
        r.busy = (bus_cmd != OP_TICK);
        r.done = cmd_closed;
        r.rx   = rx_last;
        r.ack  = ack_seen;
        return r;
    endfunction

    function automatic t_stim_row row(t_op op, logic [7:0] txb, logic sack, logic sda,
                                      int reps, logic zh);
        t_stim_row it;
        it            = '0;
        it.op         = op;
        it.txb        = txb;
        it.sack       = sack;
        it.sda        = sda;
        it.reps       = 8'(reps);
        it.zero_holds = zh;
        return it;
    endfunction

    function automatic t_stim_row checked_row(t_op op, logic [7:0] txb, logic sda, t_bus_res res);
        t_stim_row it;
        it       = row(op, txb, 1'b0, sda, 1, 1'b0);
        it.typed = 1'b1;
        it.res   = res;
        return it;
    endfunction

    // Mostly whole commands on an idle bus, ticks while busy, plus stray commands and spare codes
    function automatic t_stim_row random_item();
        t_stim_row   it;
        int unsigned pick;
        it      = row(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1, 1'b0);
        pick    = $urandom_range(0, 99);
        if (bus_cmd == OP_TICK) begin
            if (pick < 75)
                it.op = t_op'($urandom_range(OP_START, OP_READ));
            else if (pick >= 90)
                it.op = t_op'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end else begin
            if (pick < 6)
                it.op = t_op'($urandom_range(OP_START, OP_READ));
            else if (pick < 9)
                it.op = t_op'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        return it;
    endfunction

    task automatic note_failure(string what, t_bus_res want, t_bus_res got);
        n_errs++;
        if (n_errs <= 10)
            $display("%s at result %0d: exp scl=%b sda=%b busy=%b done=%b rx=%02h ack=%b rej=%b",
                     what, n_results, want.scl, want.sda, want.busy, want.done, want.rx,
                     want.ack, want.rej);
        if (n_errs <= 10)
            $display("    got scl=%b sda=%b busy=%b done=%b rx=%02h ack=%b rej=%b",
                     got.scl, got.sda, got.busy, got.done, got.rx, got.ack, got.rej);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_SHORT: hold_short = val;
            CFG_LONG:  hold_long  = val;
            CFG_WAIT:  hold_wait  = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_holds(logic [15:0] s, logic [15:0] l, logic [15:0] w);
        write_reg(CFG_SHORT, s);
        write_reg(CFG_LONG, l);
        write_reg(CFG_WAIT, w);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every transaction is taken and every result is back, then let the pipe settle
    task automatic drain_bus();
        while (random_left != 0 || item_q.size() != 0 || item_live || bus_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(logic [15:0] s, logic [15:0] l, logic [15:0] w, int n);
        drain_bus();
        set_holds(s, l, w);
        random_left = n;
    endtask

    // Sender: offer transactions in bursts and retire them into the shadow engine
    always @(posedge i_clk) begin : sender
        logic     v_next;
        t_bus_res outcome;
        v_next = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                outcome = step_bus(offer);
                bus_results_q.push_back(offer.typed ? offer.res : outcome);
                n_taken++;
                n_cmds_done += outcome.done;
                n_refused   += outcome.rej;
                v_next    = 1'b0;
                item_live = 1'b0;
            end
            if (!v_next) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (item_q.size() != 0 || random_left != 0) begin
                    if (item_q.size() != 0) begin
                        offer = item_q.pop_front();
                    end else begin
                        offer = random_item();
                        random_left--;
                    end
                    v_next       = 1'b1;
                    item_live    = 1'b1;
                    i_operation <= offer.op;
                    i_tx_byte   <= offer.txb;
                    i_send_ack  <= offer.sack;
                    i_sda_in    <= offer.sda;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        i_in_valid <= v_next;
    end

    // Receiver: stall on changing patterns, with one long hold-off to back the engine up
    initial begin : receiver
        int unsigned mode;
        int          left;
        int          hold;
        int          cyc;
        bit          held_off;
        bit          s;
        left     = 0;
        hold     = 0;
        cyc      = 0;
        held_off = 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(40, 200);
            end
            left--;
            if (!held_off && n_taken >= 300) begin
                held_off = 1'b1;
                hold     = 150;
            end
            if (hold != 0) begin
                hold--;
                s = 1'b1;
            end else begin
                case (mode)
                    0:       s = 1'b0;
                    1:       s = ($urandom_range(0, 3) == 0);
                    2:       s = ($urandom_range(0, 9) < 7);
                    default: s = ((cyc % 5) < 2);
                endcase
            end
            i_out_stall <= s;
            cyc++;
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_bus_res got;
        t_bus_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_scl_level, o_sda_level, o_busy_res, o_done_res, o_rx_byte,
                    o_ack_received, o_command_rejected};
            if (bus_results_q.size() == 0) begin
                note_failure("unexpected result", '0, got);
            end else begin
                want = bus_results_q.pop_front();
                if (got !== want)
                    note_failure("mismatch", want, got);
            end
            n_results++;
        end
    end

    // Drop out if neither channel moves for too long
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial begin : sequencer
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: idle tick, a start, a refused write, spare codes
        dir_rows.push_back(checked_row(OP_TICK, 8'h00, 1'b0, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00,
                                                              1'b0, 1'b0}));
        dir_rows.push_back(row(OP_START, 8'h00, 1'b0, 1'b1, 1, 1'b0));
        dir_rows.push_back(checked_row(OP_WRITE, 8'hFF, 1'b0, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00,
                                                                1'b0, 1'b1}));
        dir_rows.push_back(row(OP_SPARE_LO, 8'h00, 1'b0, 1'b1, 1, 1'b0));
        dir_rows.push_back(row(OP_SPARE_HI, 8'hFF, 1'b1, 1'b0, 1, 1'b0));
        // Zero holds: finish the pending start, then whole commands in one transaction each
        dir_rows.push_back(row(OP_TICK, 8'hAA, 1'b1, 1'b1, 5, 1'b1));
        dir_rows.push_back(row(OP_WRITE, 8'h00, 1'b0, 1'b0, 1, 1'b1));
        dir_rows.push_back(row(OP_WRITE, 8'hFF, 1'b1, 1'b1, 1, 1'b1));
        dir_rows.push_back(row(OP_WRITE, 8'hA5, 1'b0, 1'b0, 1, 1'b1));
        dir_rows.push_back(row(OP_READ, 8'h00, 1'b1, 1'b1, 1, 1'b1));
        dir_rows.push_back(row(OP_READ, 8'hFF, 1'b0, 1'b0, 1, 1'b1));
        dir_rows.push_back(row(OP_STOP, 8'h00, 1'b0, 1'b1, 1, 1'b1));
        dir_rows.push_back(row(OP_START, 8'h00, 1'b1, 1'b0, 1, 1'b1));
        dir_rows.push_back(row(OP_SPARE_MID, 8'h55, 1'b1, 1'b1, 1, 1'b1));
        dir_rows.push_back(row(OP_TICK, 8'h00, 1'b0, 1'b0, 1, 1'b1));

        for (int part = 0; part < 2; part++) begin
            if (part == 1) begin
                drain_bus();
                set_holds(16'd0, 16'd0, 16'd0);
            end
            foreach (dir_rows[k])
                if (dir_rows[k].zero_holds == part)
                    repeat (dir_rows[k].reps) item_q.push_back(dir_rows[k]);
        end

        // Random traffic over several hold settings, the largest last
        run_random(16'd1, 16'd1, 16'd0, 220);
        drain_bus();
        write_reg(CFG_UNUSED, 16'($urandom));
        run_random(16'($urandom_range(1, 3)), 16'($urandom_range(1, 4)),
                   16'($urandom_range(0, 2)), 200);
        run_random(16'd0, 16'd0, 16'd0, 120);
        run_random(16'd2, 16'd5, 16'd1, 150);
        run_random(16'hFFFF, 16'hFFFF, 16'hFFFF, 40);
        drain_bus();

        $display("tb_top: %0d transactions in, %0d results checked, %0d commands completed",
                 n_taken, n_results, n_cmds_done);
        $display("tb_top: %0d commands refused while busy, holds from 0 to 65535, %0d mismatches",
                 n_refused, n_errs);
        if (n_errs == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
